@@ hw/rtl/tlct_pkg.sv @@
`default_nettype none

package tlct_pkg;

    typedef enum logic [2:0] {
        REG_L1_LEN  = 3'd0,
        REG_L2_LEN  = 3'd1,
        REG_L1_MASS = 3'd2,
        REG_L2_MASS = 3'd3,
        REG_GRAVITY = 3'd4,
        REG_KP      = 3'd5,
        REG_KD      = 3'd6
    } cfg_reg_t;

    localparam logic [15:0] L1_LEN_RST  = 16'd4096;
    localparam logic [15:0] L2_LEN_RST  = 16'd4096;
    localparam logic [15:0] L1_MASS_RST = 16'd256;
    localparam logic [15:0] L2_MASS_RST = 16'd256;
    localparam logic [15:0] GRAVITY_RST = 16'd2511;

    // round(2^32 / (2 pi)) and pi/2 in Q30
    localparam logic [47:0] PHASE_SCALE = 48'd683565276;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [23:0] TORQUE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] TORQUE_MIN = 24'sh800000;

    // First-quadrant sine sample j of a table with 2^bits entries per turn, Q1.14.
    // Evaluated at elaboration only.
    function automatic logic [14:0] quarter_sine(input int unsigned j,
                                                 input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 n;
        x = (64'(j) * HALF_PI_Q30) >> (bits - 2);
        sum = $signed(x);
        term = x;
        for (n = 1; n <= 5; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (n)
                1: term = term / 64'd6;
                2: term = term / 64'd20;
                3: term = term / 64'd42;
                4: term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        sum = (sum + 64'sd32768) >>> 16;
        if (sum > 64'sd16384) begin
            sum = 64'sd16384;
        end
        return sum[14:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/two_link_computed_torque.sv @@
// Two-link arm computed-torque controller.
// Throughput one request per cycle while m_tready does not stall the output,
// set by a 7-stage pipeline with a valid bit per stage and per-stage ready (bubbles collapse).
// Arm terms derived from the link registers are registered (products, then a/b/d/p1/p2) and lag a register write.
// Reset (aresetn low, synchronous) empties the pipeline and loads register defaults;
// there is no clearing pass.
`default_nettype none

module two_link_computed_torque #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // angle_one, angle_two, rate_one, rate_two, target_one, target_two (16 bits each)
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // torque_one [23:0], torque_two [47:24]
    output logic [47:0]      m_tdata,
    // clipped
    output logic             m_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_index,
    input  wire logic [63:0] cfg_wr_data
);
    import tlct_pkg::*;

    localparam int TB = SINE_TABLE_BITS;
    localparam int QN = 1 << (TB - 2);
    localparam int SH = 45 - TB;
    localparam logic [TB-2:0] QIDX = (TB-1)'(QN);
    localparam logic [TB-1:0] QPH  = TB'(QN);
    localparam logic signed [47:0] PS_S = $signed(PHASE_SCALE);
    localparam logic [47:0] PH_HALF = 48'(1) << (SH - 1);
    localparam logic signed [54:0] T_MAX = 55'(TORQUE_MAX);
    localparam logic signed [54:0] T_MIN = 55'(TORQUE_MIN);

    typedef struct packed {
        logic          neg;
        logic [TB-2:0] idx;
    } trig_sel_t;

    // ---------------- sine table ----------------
    logic [14:0] sin_rom [0:QN];
    for (genvar gi = 0; gi <= QN; gi++) begin : g_sin
        localparam logic [14:0] SV = quarter_sine(gi, TB);
        assign sin_rom[gi] = SV;
    end

    function automatic logic [TB-1:0] phase_of(input logic signed [16:0] a);
        logic [47:0] p;
        p = 48'(48'(a) * PS_S) + PH_HALF;
        return p[SH+TB-1:SH];
    endfunction

    function automatic trig_sel_t trig_sel(input logic [TB-1:0] k);
        trig_sel_t r;
        r.neg = k[TB-1];
        r.idx = k[TB-2] ? (QIDX - {1'b0, k[TB-3:0]}) : {1'b0, k[TB-3:0]};
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [15:0] l1_reg, l2_reg, m1_reg, m2_reg, gc_reg;
    logic [63:0] kp_reg, kd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg <= L1_LEN_RST;
            l2_reg <= L2_LEN_RST;
            m1_reg <= L1_MASS_RST;
            m2_reg <= L2_MASS_RST;
            gc_reg <= GRAVITY_RST;
            kp_reg <= '0;
            kd_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_L1_LEN:  l1_reg <= cfg_wr_data[15:0];
                REG_L2_LEN:  l2_reg <= cfg_wr_data[15:0];
                REG_L1_MASS: m1_reg <= cfg_wr_data[15:0];
                REG_L2_MASS: m2_reg <= cfg_wr_data[15:0];
                REG_GRAVITY: gc_reg <= cfg_wr_data[15:0];
                REG_KP:      kp_reg <= cfg_wr_data;
                REG_KD:      kd_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // arm constants: products registered, then a, b, d, p1, p2 registered from them and the registers
    logic [16:0] m12;
    logic [31:0] l22_next, l12_next, l11_next, m2l2_next;
    logic [32:0] m12l1_next;
    logic [31:0] l22_reg, l12_reg, l11_reg, m2l2_reg;
    logic [32:0] m12l1_reg;
    logic [47:0] ap, bp, p2p;
    logic [48:0] dp, p1p;
    logic [27:0] a_next, b_next, a_reg, b_reg;
    logic [28:0] d_next, d_reg;
    logic [31:0] p2_next, p2_reg;
    logic [32:0] p1_next, p1_reg;

    always_comb begin
        m12        = 17'(m1_reg) + 17'(m2_reg);
        l22_next   = 32'(l2_reg) * 32'(l2_reg);
        l12_next   = 32'(l1_reg) * 32'(l2_reg);
        l11_next   = 32'(l1_reg) * 32'(l1_reg);
        m2l2_next  = 32'(m2_reg) * 32'(l2_reg);
        m12l1_next = 33'(m12) * 33'(l1_reg);
        ap  = 48'(l22_reg) * 48'(m2_reg) + 48'(1 << 19);
        bp  = 48'(l12_reg) * 48'(m2_reg) + 48'(1 << 19);
        dp  = 49'(l11_reg) * 49'(m12) + 49'(1 << 19);
        p2p = 48'(m2l2_reg) * 48'(gc_reg) + 48'(1 << 15);
        p1p = 49'(m12l1_reg) * 49'(gc_reg) + 49'(1 << 15);
        a_next  = ap[47:20];
        b_next  = bp[47:20];
        d_next  = dp[48:20];
        p2_next = p2p[47:16];
        p1_next = p1p[48:16];
    end

    always_ff @(posedge aclk) begin
        l22_reg   <= l22_next;
        l12_reg   <= l12_next;
        l11_reg   <= l11_next;
        m2l2_reg  <= m2l2_next;
        m12l1_reg <= m12l1_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        d_reg     <= d_next;
        p2_reg    <= p2_next;
        p1_reg    <= p1_next;
    end

    // ---------------- pipeline control ----------------
    logic [7:1] vld_reg, vld_next, rdy;

    always_comb begin
        rdy[7] = !vld_reg[7] || m_tready;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[1] = rdy[1] ? s_tvalid : vld_reg[1];
        for (int k = 2; k <= 7; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[7];

    // ---------------- stage 1: errors and phases ----------------
    logic signed [15:0] q0, q1, dq0, dq1, r0, r1;
    logic signed [16:0] e0_next, e1_next, de0_next, de1_next;
    logic signed [16:0] e0_1_reg, e1_1_reg, de0_1_reg, de1_1_reg;
    logic signed [15:0] dq0_1_reg, dq1_1_reg;
    logic [TB-1:0] k0_next, k1_next, k01_next, k0_1_reg, k1_1_reg, k01_1_reg;

    always_comb begin
        q0  = $signed(s_tdata[15:0]);
        q1  = $signed(s_tdata[31:16]);
        dq0 = $signed(s_tdata[47:32]);
        dq1 = $signed(s_tdata[63:48]);
        r0  = $signed(s_tdata[79:64]);
        r1  = $signed(s_tdata[95:80]);
        e0_next  = 17'(r0) - 17'(q0);
        e1_next  = 17'(r1) - 17'(q1);
        de0_next = -17'(dq0);
        de1_next = -17'(dq1);
        k0_next  = phase_of(17'(q0));
        k1_next  = phase_of(17'(q1));
        k01_next = phase_of(17'(q0) + 17'(q1));
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            e0_1_reg  <= e0_next;
            e1_1_reg  <= e1_next;
            de0_1_reg <= de0_next;
            de1_1_reg <= de1_next;
            dq0_1_reg <= dq0;
            dq1_1_reg <= dq1;
            k0_1_reg  <= k0_next;
            k1_1_reg  <= k1_next;
            k01_1_reg <= k01_next;
        end
    end

    // ---------------- stage 2: gain products, trig, rate products ----------------
    logic signed [32:0] vd0a_next, vd0b_next, vd1a_next, vd1b_next;
    logic signed [32:0] vp0a_next, vp0b_next, vp1a_next, vp1b_next;
    logic signed [32:0] vd0a_reg, vd0b_reg, vd1a_reg, vd1b_reg;
    logic signed [32:0] vp0a_reg, vp0b_reg, vp1a_reg, vp1b_reg;
    trig_sel_t ts_c1, ts_c12, ts_s2, ts_c2;
    logic signed [15:0] c1_next, c12_next, s2_next, c2_next;
    logic signed [15:0] c1_2_reg, c12_2_reg, s2_2_reg, c2_2_reg;
    logic signed [31:0] pp00_next, pp01_next, pp11_next, pp00_reg, pp01_reg, pp11_reg;
    logic signed [15:0] sv_c1, sv_c12, sv_s2, sv_c2;

    always_comb begin
        vd0a_next = 33'($signed(kd_reg[15:0]))  * 33'(de0_1_reg);
        vd0b_next = 33'($signed(kd_reg[31:16])) * 33'(de1_1_reg);
        vd1a_next = 33'($signed(kd_reg[47:32])) * 33'(de0_1_reg);
        vd1b_next = 33'($signed(kd_reg[63:48])) * 33'(de1_1_reg);
        vp0a_next = 33'($signed(kp_reg[15:0]))  * 33'(e0_1_reg);
        vp0b_next = 33'($signed(kp_reg[31:16])) * 33'(e1_1_reg);
        vp1a_next = 33'($signed(kp_reg[47:32])) * 33'(e0_1_reg);
        vp1b_next = 33'($signed(kp_reg[63:48])) * 33'(e1_1_reg);

        ts_c1  = trig_sel(k0_1_reg + QPH);
        ts_c12 = trig_sel(k01_1_reg + QPH);
        ts_s2  = trig_sel(k1_1_reg);
        ts_c2  = trig_sel(k1_1_reg + QPH);
        sv_c1  = $signed({1'b0, sin_rom[ts_c1.idx]});
        sv_c12 = $signed({1'b0, sin_rom[ts_c12.idx]});
        sv_s2  = $signed({1'b0, sin_rom[ts_s2.idx]});
        sv_c2  = $signed({1'b0, sin_rom[ts_c2.idx]});
        c1_next  = ts_c1.neg  ? -sv_c1  : sv_c1;
        c12_next = ts_c12.neg ? -sv_c12 : sv_c12;
        s2_next  = ts_s2.neg  ? -sv_s2  : sv_s2;
        c2_next  = ts_c2.neg  ? -sv_c2  : sv_c2;

        pp00_next = 32'(dq0_1_reg) * 32'(dq0_1_reg);
        pp01_next = 32'(dq0_1_reg) * 32'(dq1_1_reg);
        pp11_next = 32'(dq1_1_reg) * 32'(dq1_1_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            vd0a_reg  <= vd0a_next;
            vd0b_reg  <= vd0b_next;
            vd1a_reg  <= vd1a_next;
            vd1b_reg  <= vd1b_next;
            vp0a_reg  <= vp0a_next;
            vp0b_reg  <= vp0b_next;
            vp1a_reg  <= vp1a_next;
            vp1b_reg  <= vp1b_next;
            c1_2_reg  <= c1_next;
            c12_2_reg <= c12_next;
            s2_2_reg  <= s2_next;
            c2_2_reg  <= c2_next;
            pp00_reg  <= pp00_next;
            pp01_reg  <= pp01_next;
            pp11_reg  <= pp11_next;
        end
    end

    // ---------------- stage 3: v, b*cos, b*sin, gravity terms ----------------
    logic signed [37:0] vs0, vs1;
    logic signed [44:0] bcp, bsp;
    logic signed [48:0] gp2p;
    logic signed [49:0] gp1p;
    logic signed [29:0] v0_3_next, v1_3_next, v0_3_reg, v1_3_reg;
    logic signed [30:0] bc_3_next, bs_3_next, bc_3_reg, bs_3_reg;
    logic signed [34:0] gp2_3_next, gp2_3_reg;
    logic signed [35:0] gp1_3_next, gp1_3_reg;
    logic signed [33:0] w0_3_next, w0_3_reg;
    logic signed [31:0] w1_3_reg;

    always_comb begin
        vs0 = ((38'(vd0a_reg) + 38'(vd0b_reg)) <<< 3) + 38'(vp0a_reg) + 38'(vp0b_reg)
              + 38'sd256;
        vs1 = ((38'(vd1a_reg) + 38'(vd1b_reg)) <<< 3) + 38'(vp1a_reg) + 38'(vp1b_reg)
              + 38'sd256;
        v0_3_next = 30'(vs0 >>> 9);
        v1_3_next = 30'(vs1 >>> 9);
        bcp = 45'($signed({1'b0, b_reg})) * 45'(c2_2_reg) + 45'sd8192;
        bsp = 45'($signed({1'b0, b_reg})) * 45'(s2_2_reg) + 45'sd8192;
        bc_3_next = 31'(bcp >>> 14);
        bs_3_next = 31'(bsp >>> 14);
        gp2p = 49'($signed({1'b0, p2_reg})) * 49'(c12_2_reg) + 49'sd8192;
        gp1p = 50'($signed({1'b0, p1_reg})) * 50'(c1_2_reg) + 50'sd8192;
        gp2_3_next = 35'(gp2p >>> 14);
        gp1_3_next = 36'(gp1p >>> 14);
        w0_3_next = 34'(pp11_reg) + (34'(pp01_reg) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            v0_3_reg  <= v0_3_next;
            v1_3_reg  <= v1_3_next;
            bc_3_reg  <= bc_3_next;
            bs_3_reg  <= bs_3_next;
            gp2_3_reg <= gp2_3_next;
            gp1_3_reg <= gp1_3_next;
            w0_3_reg  <= w0_3_next;
            w1_3_reg  <= pp00_reg;
        end
    end

    // ---------------- stage 4: mass matrix, Coriolis partial products ----------------
    logic signed [32:0] m00_4_next, m00_4_reg;
    logic signed [31:0] m01_4_next, m01_4_reg;
    logic signed [36:0] g0_4_next, g0_4_reg;
    logic signed [34:0] g1_4_reg;
    logic signed [48:0] ccp0l_next, ccp0l_reg;
    logic signed [47:0] ccp0h_next, ccp1l_next, ccp1h_next;
    logic signed [47:0] ccp0h_reg, ccp1l_reg, ccp1h_reg;
    logic signed [29:0] v0_4_reg, v1_4_reg;

    always_comb begin
        m00_4_next = $signed({5'b0, a_reg}) + (33'(bc_3_reg) <<< 1) + $signed({4'b0, d_reg});
        m01_4_next = $signed({4'b0, a_reg}) + 32'(bc_3_reg);
        g0_4_next  = 37'(gp2_3_reg) + 37'(gp1_3_reg);
        // split the rate term so each multiply stays narrow
        ccp0l_next = 49'(bs_3_reg) * 49'($signed({1'b0, w0_3_reg[16:0]}));
        ccp0h_next = 48'(bs_3_reg) * 48'($signed(w0_3_reg[33:17]));
        ccp1l_next = 48'(bs_3_reg) * 48'($signed({1'b0, w1_3_reg[15:0]}));
        ccp1h_next = 48'(bs_3_reg) * 48'($signed(w1_3_reg[31:16]));
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            m00_4_reg <= m00_4_next;
            m01_4_reg <= m01_4_next;
            g0_4_reg  <= g0_4_next;
            g1_4_reg  <= gp2_3_reg;
            ccp0l_reg <= ccp0l_next;
            ccp0h_reg <= ccp0h_next;
            ccp1l_reg <= ccp1l_next;
            ccp1h_reg <= ccp1h_next;
            v0_4_reg  <= v0_3_reg;
            v1_4_reg  <= v1_3_reg;
        end
    end

    // ---------------- stage 5: M*v partial products, Coriolis terms ----------------
    logic signed [15:0] vl0, vl1;
    logic signed [14:0] vh0, vh1;
    logic signed [28:0] a_s;
    logic signed [48:0] mv00l_next, mv01l_next, mv10l_next, mv11l_next;
    logic signed [47:0] mv00h_next, mv01h_next, mv10h_next, mv11h_next;
    logic signed [48:0] mv00l_reg, mv01l_reg, mv10l_reg, mv11l_reg;
    logic signed [47:0] mv00h_reg, mv01h_reg, mv10h_reg, mv11h_reg;
    logic signed [64:0] ccs0;
    logic signed [65:0] ccn0;
    logic signed [63:0] ccs1;
    logic signed [46:0] cc0_5_next, cc0_5_reg;
    logic signed [44:0] cc1_5_next, cc1_5_reg;
    logic signed [36:0] g0_5_reg;
    logic signed [34:0] g1_5_reg;

    always_comb begin
        vl0 = $signed({1'b0, v0_4_reg[14:0]});
        vl1 = $signed({1'b0, v1_4_reg[14:0]});
        vh0 = $signed(v0_4_reg[29:15]);
        vh1 = $signed(v1_4_reg[29:15]);
        a_s = $signed({1'b0, a_reg});
        mv00l_next = 49'(m00_4_reg) * 49'(vl0);
        mv00h_next = 48'(m00_4_reg) * 48'(vh0);
        mv01l_next = 49'(m01_4_reg) * 49'(vl1);
        mv01h_next = 48'(m01_4_reg) * 48'(vh1);
        mv10l_next = 49'(m01_4_reg) * 49'(vl0);
        mv10h_next = 48'(m01_4_reg) * 48'(vh0);
        mv11l_next = 49'(a_s) * 49'(vl1);
        mv11h_next = 48'(a_s) * 48'(vh1);
        ccs0 = (65'(ccp0h_reg) <<< 17) + 65'(ccp0l_reg);
        ccn0 = -66'(ccs0) + 66'sd524288;
        cc0_5_next = 47'(ccn0 >>> 20);
        ccs1 = (64'(ccp1h_reg) <<< 16) + 64'(ccp1l_reg) + 64'sd524288;
        cc1_5_next = 45'(ccs1 >>> 20);
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            mv00l_reg <= mv00l_next;
            mv00h_reg <= mv00h_next;
            mv01l_reg <= mv01l_next;
            mv01h_reg <= mv01h_next;
            mv10l_reg <= mv10l_next;
            mv10h_reg <= mv10h_next;
            mv11l_reg <= mv11l_next;
            mv11h_reg <= mv11h_next;
            cc0_5_reg <= cc0_5_next;
            cc1_5_reg <= cc1_5_next;
            g0_5_reg  <= g0_4_reg;
            g1_5_reg  <= g1_4_reg;
        end
    end

    // ---------------- stage 6: M*v sums, Coriolis plus gravity sums ----------------
    logic signed [63:0] mv0_6_next, mv1_6_next, mv0_6_reg, mv1_6_reg;
    logic signed [47:0] cg0_6_next, cg1_6_next, cg0_6_reg, cg1_6_reg;

    always_comb begin
        mv0_6_next = (64'(mv00h_reg) <<< 15) + 64'(mv00l_reg)
                   + (64'(mv01h_reg) <<< 15) + 64'(mv01l_reg);
        mv1_6_next = (64'(mv10h_reg) <<< 15) + 64'(mv10l_reg)
                   + (64'(mv11h_reg) <<< 15) + 64'(mv11l_reg);
        cg0_6_next = 48'(cc0_5_reg) + 48'(g0_5_reg);
        cg1_6_next = 48'(cc1_5_reg) + 48'(g1_5_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            mv0_6_reg <= mv0_6_next;
            mv1_6_reg <= mv1_6_next;
            cg0_6_reg <= cg0_6_next;
            cg1_6_reg <= cg1_6_next;
        end
    end

    // ---------------- stage 7: torque and saturation ----------------
    logic signed [63:0] mr0, mr1;
    logic signed [54:0] t0, t1;
    logic signed [23:0] torque_one_next, torque_two_next, torque_one_reg, torque_two_reg;
    logic clip_next, clip_reg;

    always_comb begin
        mr0 = (mv0_6_reg + 64'sd2048) >>> 12;
        mr1 = (mv1_6_reg + 64'sd2048) >>> 12;
        t0 = 55'(mr0) + 55'(cg0_6_reg);
        t1 = 55'(mr1) + 55'(cg1_6_reg);
        clip_next = 1'b0;
        priority if (t0 > T_MAX) begin
            torque_one_next = TORQUE_MAX;
            clip_next = 1'b1;
        end else if (t0 < T_MIN) begin
            torque_one_next = TORQUE_MIN;
            clip_next = 1'b1;
        end else begin
            torque_one_next = t0[23:0];
        end
        priority if (t1 > T_MAX) begin
            torque_two_next = TORQUE_MAX;
            clip_next = 1'b1;
        end else if (t1 < T_MIN) begin
            torque_two_next = TORQUE_MIN;
            clip_next = 1'b1;
        end else begin
            torque_two_next = t1[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            torque_one_reg <= torque_one_next;
            torque_two_reg <= torque_two_next;
            clip_reg       <= clip_next;
        end
    end

    assign m_tdata = {torque_two_reg, torque_one_reg};
    assign m_tuser = clip_reg;

    // ---------------- assertions ----------------
    a_clip_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (torque_one_reg == TORQUE_MAX || torque_one_reg == TORQUE_MIN ||
             torque_two_reg == TORQUE_MAX || torque_two_reg == TORQUE_MIN))
        else $error("clip flag without a saturated torque");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[6] && rdy[6]) |=> m_tvalid)
        else $error("request lost entering the output stage");

endmodule

`default_nettype wire

@@ tb/tb_two_link_computed_torque.sv @@
`timescale 1ns / 100ps
`default_nettype none

module tb_two_link_computed_torque;
    import tlct_pkg::*;

    localparam int SINE_BITS = 10;
    localparam int QUARTER = 1 << (SINE_BITS - 2);
    localparam int LATENCY = 12;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD = 300;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [23:0] torque_one;
        logic [23:0] torque_two;
        logic        clipped;
    } torque_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_index = '0;
    logic [63:0] cfg_wr_data = '0;

    two_link_computed_torque #(.SINE_TABLE_BITS(SINE_BITS)) DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // arm estimate and gains as the block should hold them
    logic [15:0] len1, len2, mass1, mass2, grav;
    logic [63:0] kp, kd;
    longint      sine_tbl[QUARTER+1];

    logic [95:0] pending_reqs[$];
    torque_t     torque_exp[$];
    int          errors = 0;
    logic        no_idle = 1'b0;
    int          hold_seq = 0;

    function automatic longint quarter_wave(int j);
        logic [63:0] x, term;
        longint      sum;
        x = (64'(j) * 64'd1686629713) >> (SINE_BITS - 2);
        sum = longint'(x);
        term = x;
        for (int n = 1; n <= 5; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        sum = (sum + 32768) >>> 16;
        return (sum > 16384) ? 16384 : sum;
    endfunction

    function automatic longint rnd(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic int phase_idx(longint a);
        logic [63:0] p;
        p = 64'(a) * 64'd683565276 + (64'd1 << (44 - SINE_BITS));
        return int'((p >> (45 - SINE_BITS)) & ((64'd1 << SINE_BITS) - 1));
    endfunction

    function automatic longint sine_of(int k);
        int     quad, j;
        longint s;
        quad = (k >> (SINE_BITS - 2)) & 3;
        j = k & (QUARTER - 1);
        s = (quad & 1) ? sine_tbl[QUARTER - j] : sine_tbl[j];
        return (quad & 2) ? -s : s;
    endfunction

    function automatic longint cosine_of(int k);
        return sine_of((k + QUARTER) & ((1 << SINE_BITS) - 1));
    endfunction

    function automatic longint gain_at(logic [63:0] g, int idx);
        return longint'($signed(g[16*idx +: 16]));
    endfunction

    function automatic longint clamp(longint t, inout logic clip);
        if (t > 8388607) begin clip = 1'b1; return 8388607; end
        if (t < -8388608) begin clip = 1'b1; return -8388608; end
        return t;
    endfunction

    function automatic torque_t compute_torque(logic [95:0] d);
        longint q0, q1, dq0, dq1, e0, e1, v0, v1, l1, l2, m2, m12, gc;
        longint cq0, cq01, sq1, cq1, a, b, dd, bc, bs, mm00, mm01, mm11;
        longint cc0, cc1, p1, p2, g0, g1, t0, t1;
        logic    clip;
        torque_t r;
        q0 = $signed(d[15:0]);  q1 = $signed(d[31:16]);
        dq0 = $signed(d[47:32]); dq1 = $signed(d[63:48]);
        e0 = longint'($signed(d[79:64])) - q0;
        e1 = longint'($signed(d[95:80])) - q1;
        l1 = len1; l2 = len2; m2 = mass2; m12 = longint'(mass1) + m2; gc = grav;
        clip = 1'b0;
        v0 = rnd(8 * (gain_at(kd, 0) * -dq0 + gain_at(kd, 1) * -dq1)
                 + gain_at(kp, 0) * e0 + gain_at(kp, 1) * e1, 9);
        v1 = rnd(8 * (gain_at(kd, 2) * -dq0 + gain_at(kd, 3) * -dq1)
                 + gain_at(kp, 2) * e0 + gain_at(kp, 3) * e1, 9);
        cq0 = cosine_of(phase_idx(q0));
        cq01 = cosine_of(phase_idx(q0 + q1));
        sq1 = sine_of(phase_idx(q1));
        cq1 = cosine_of(phase_idx(q1));
        a = rnd(l2 * l2 * m2, 20);
        b = rnd(l1 * l2 * m2, 20);
        dd = rnd(l1 * l1 * m12, 20);
        bc = rnd(b * cq1, 14);
        bs = rnd(b * sq1, 14);
        mm00 = a + 2 * bc + dd;
        mm01 = a + bc;
        mm11 = a;
        cc0 = rnd(-bs * (dq1 * dq1 + 2 * dq0 * dq1), 20);
        cc1 = rnd(bs * (dq0 * dq0), 20);
        p2 = rnd(m2 * l2 * gc, 16);
        p1 = rnd(m12 * l1 * gc, 16);
        g1 = rnd(p2 * cq01, 14);
        g0 = g1 + rnd(p1 * cq0, 14);
        t0 = clamp(rnd(mm00 * v0 + mm01 * v1, 12) + cc0 + g0, clip);
        t1 = clamp(rnd(mm01 * v0 + mm11 * v1, 12) + cc1 + g1, clip);
        r.torque_one = t0[23:0];
        r.torque_two = t1[23:0];
        r.clipped = clip;
        return r;
    endfunction

    // request driver
    logic [95:0] cur_req;
    int          s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) torque_exp = {torque_exp, compute_torque(cur_req)};
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0 || pending_reqs.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (s_gap > 0) s_gap <= s_gap - 1;
                end else begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata <= cur_req;
                    s_tvalid <= 1'b1;
                    s_gap <= no_idle ? 0 : $urandom_range(0, 7);
                end
            end
        end
    end

    // result monitor
    int m_gap = 0;
    int hold_cnt = 0;
    int hold_seen = 0;
    always @(posedge aclk) begin
        torque_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[23:0], m_tdata[47:24], m_tuser};
                if (torque_exp.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h/%h clip %b", $time,
                             got.torque_one, got.torque_two, got.clipped);
                end else begin
                    want = torque_exp.pop_front();
                    if (got.torque_one !== want.torque_one) begin
                        errors++;
                        $display("%0t: torque_one exp %h got %h", $time,
                                 want.torque_one, got.torque_one);
                    end
                    if (got.torque_two !== want.torque_two) begin
                        errors++;
                        $display("%0t: torque_two exp %h got %h", $time,
                                 want.torque_two, got.torque_two);
                    end
                    if (got.clipped !== want.clipped) begin
                        errors++;
                        $display("%0t: clipped exp %b got %b", $time,
                                 want.clipped, got.clipped);
                    end
                end
                m_gap = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (hold_seq != hold_seen) begin
                hold_seen <= hold_seq;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on stalled traffic
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else if (pending_reqs.size() != 0 || torque_exp.size() != 0) quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_L1_LEN:  len1 = val[15:0];
            REG_L2_LEN:  len2 = val[15:0];
            REG_L1_MASS: mass1 = val[15:0];
            REG_L2_MASS: mass2 = val[15:0];
            REG_GRAVITY: grav = val[15:0];
            REG_KP:      kp = val;
            REG_KD:      kd = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_arm(logic [15:0] l1v, l2v, m1v, m2v, gv, logic [63:0] kpv, kdv);
        write_reg(REG_L1_LEN, 64'(l1v));
        write_reg(REG_L2_LEN, 64'(l2v));
        write_reg(REG_L1_MASS, 64'(m1v));
        write_reg(REG_L2_MASS, 64'(m2v));
        write_reg(REG_GRAVITY, 64'(gv));
        write_reg(REG_KP, kpv);
        write_reg(REG_KD, kdv);
        repeat (4) @(posedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || torque_exp.size() != 0)
            @(negedge aclk);
        repeat (LATENCY) @(negedge aclk);
    endtask

    function automatic logic [63:0] small_gains();
        logic [63:0] g;
        for (int i = 0; i < 4; i++) g[16*i +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
        return g;
    endfunction

    function automatic logic [95:0] rand_req(bit full);
        logic [95:0] d;
        for (int i = 0; i < 6; i++)
            d[16*i +: 16] = full ? 16'($urandom) : 16'($signed($urandom_range(0, 8192)) - 4096);
        return d;
    endfunction

    task automatic push_random(int n);
        for (int i = 0; i < n; i++) begin
            @(negedge aclk);
            pending_reqs = {pending_reqs, rand_req($urandom_range(0, 1) == 1)};
        end
    endtask

    initial begin
        logic [15:0] ext[6];
        len1 = L1_LEN_RST; len2 = L2_LEN_RST; mass1 = L1_MASS_RST;
        mass2 = L2_MASS_RST; grav = GRAVITY_RST; kp = '0; kd = '0;
        for (int j = 0; j <= QUARTER; j++) sine_tbl[j] = quarter_wave(j);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // reset values, directed extremes
        ext = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h3243};
        @(negedge aclk);
        for (int i = 0; i < 6; i++)
            for (int k = 0; k < 3; k++)
                pending_reqs = {pending_reqs,
                                {6{ext[(i + k) % 6]}} ^ (96'hFFFF << (16 * i))};
        pending_reqs = {pending_reqs, 96'd0};
        push_random(60);
        drain();

        // moderate gains; long receiver hold-off while requests keep coming
        set_arm(16'd4096, 16'd3000, 16'd512, 16'd300, 16'd2511, small_gains(), small_gains());
        @(negedge aclk);
        hold_seq <= hold_seq + 1;
        no_idle <= 1'b1;
        push_random(90);
        drain();
        no_idle <= 1'b0;
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);

        // everything at its maximum: saturation
        set_arm(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        @(negedge aclk);
        pending_reqs = {pending_reqs, 96'h8000_8000_7FFF_7FFF_8000_8000};
        pending_reqs = {pending_reqs, 96'h7FFF_7FFF_8000_8000_7FFF_7FFF};
        push_random(80);
        drain();

        // most negative gains, zero arm
        set_arm(16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
        push_random(70);
        drain();

        // fully random settings
        for (int p = 0; p < 3; p++) begin
            set_arm(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    {$urandom, $urandom}, {$urandom, $urandom});
            push_random(50);
            drain();
        end

        // realistic arm, moderate gains
        set_arm(16'd2048, 16'd1536, 16'd640, 16'd384, 16'd2511, small_gains(), small_gains());
        push_random(80);
        drain();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
